// ===== rtl/stepper_ramp_and_position_control_assert.svh =====
// Assertion macros shared by the stepper controller RTL.
`ifndef STEPPER_RAMP_AND_POSITION_CONTROL_ASSERT_SVH
`define STEPPER_RAMP_AND_POSITION_CONTROL_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SRPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srpc: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SRPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srpc: next-cycle check failed");

`endif

// ===== rtl/srpc_pkg.sv =====
// Types, constants and codes shared by the stepper controller modules.
`default_nettype none
package srpc_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int TIME_W     = 32;
  localparam int RPM_W      = 20;
  localparam int SLOPE_W    = 22;
  localparam int TURNS_W    = 30;
  localparam int PERIOD_W   = 16;
  localparam int SPT_W      = 16;
  localparam int SPR_W      = 11;
  localparam int TONE_W     = 27;
  localparam int POS_W      = 32;
  localparam int TURN_FRAC  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_USER_W  = 3;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 88;

  // dt * slope is clamped to PROD_W bits, then divided by 1000 via reciprocal
  localparam int PROD_W     = 31;
  localparam int DELTA_W    = 22;
  localparam int DIV_SHIFT  = 41;
  localparam logic [31:0] DIV1000_MAGIC = 32'd2199023256;
  localparam logic [PROD_W-1:0] PROD_MAX = {PROD_W{1'b1}};
  localparam logic [TONE_W-1:0] TONE_MAX = {TONE_W{1'b1}};

  localparam logic [IN_USER_W-1:0] OP_TICK   = 3'd0;
  localparam logic [IN_USER_W-1:0] OP_START  = 3'd1;
  localparam logic [IN_USER_W-1:0] OP_ROTATE = 3'd2;
  localparam logic [IN_USER_W-1:0] OP_RESREF = 3'd3;
  localparam logic [IN_USER_W-1:0] OP_STOP   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_TURN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_RPM   = 2'd3;

  localparam logic [PERIOD_W-1:0] RAMP_PERIOD_RST = 16'd50;
  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd2;
  localparam logic [SPT_W-1:0]    STEPS_TURN_RST  = 16'd14400;
  localparam logic [SPR_W-1:0]    STEPS_RPM_RST   = 11'd240;
  localparam logic [SLOPE_W-1:0]  SLOPE_RST       = SLOPE_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_START,
    CMD_ROTATE,
    CMD_RESREF,
    CMD_STOP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_IMPULSE = 2'd1,
    MODE_RATE    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    BK_EXEC,
    BK_MUL,
    BK_DIV,
    BK_UPD,
    BK_TONE
  } bk_state_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] ramp_period_ms;
    logic [PERIOD_W-1:0] step_period_ms;
    logic [SPT_W-1:0]    steps_per_turn;
    logic [SPR_W-1:0]    steps_per_sec_per_rpm;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [TIME_W-1:0]         time_ms;
    logic signed [RPM_W-1:0]   target_rpm;
    logic [SLOPE_W-1:0]        ramp_rate;
    logic [POS_W-1:0]          goal_steps;
  } cmd_t;

  typedef struct packed {
    logic                      ramping;
    logic                      rotating;
    logic [POS_W-1:0]          position_steps;
    logic [RPM_W-1:0]          speed_rpm;
    logic [TONE_W-1:0]         step_rate;
    logic [1:0]                drive_mode;
    logic                      driver_enable;
    logic                      step_dir;
    logic                      step_pulse;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/srpc_front.sv =====
// Front end: decodes incoming requests and converts rotate targets to steps.
`default_nettype none
module srpc_front (
  input  wire logic [srpc_pkg::IN_USER_W-1:0] in_tuser,
  input  wire logic [srpc_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [srpc_pkg::SPT_W-1:0]     steps_per_turn,
  output srpc_pkg::cmd_t                      cmd
);

  logic signed [srpc_pkg::TURNS_W-1:0] turns;
  logic        [srpc_pkg::TURNS_W-1:0] turns_mag;
  logic        [srpc_pkg::TURNS_W+srpc_pkg::SPT_W-1:0] goal_prod;
  logic        [srpc_pkg::TURNS_W+srpc_pkg::SPT_W:0]   goal_round;
  logic        [srpc_pkg::POS_W-1:0]   goal_mag;
  srpc_pkg::cmd_kind_t                 kind;

  assign turns     = in_tdata[103:74];
  assign turns_mag = turns[srpc_pkg::TURNS_W-1] ? (srpc_pkg::TURNS_W'(0) - turns) : turns;
  assign goal_prod = (srpc_pkg::TURNS_W+srpc_pkg::SPT_W)'(turns_mag)
                   * (srpc_pkg::TURNS_W+srpc_pkg::SPT_W)'(steps_per_turn);
  // round half away from zero on the magnitude
  assign goal_round = (srpc_pkg::TURNS_W+srpc_pkg::SPT_W+1)'(goal_prod)
                    + ((srpc_pkg::TURNS_W+srpc_pkg::SPT_W+1)'(1) << (srpc_pkg::TURN_FRAC-1));
  assign goal_mag  = srpc_pkg::POS_W'(goal_round >> srpc_pkg::TURN_FRAC);

  always_comb begin
    case (in_tuser)
      srpc_pkg::OP_TICK:   kind = srpc_pkg::CMD_TICK;
      srpc_pkg::OP_START:  kind = srpc_pkg::CMD_START;
      srpc_pkg::OP_ROTATE: kind = srpc_pkg::CMD_ROTATE;
      srpc_pkg::OP_RESREF: kind = srpc_pkg::CMD_RESREF;
      srpc_pkg::OP_STOP:   kind = srpc_pkg::CMD_STOP;
      default:             kind = srpc_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    cmd.kind       = kind;
    cmd.time_ms    = in_tdata[31:0];
    cmd.target_rpm = in_tdata[51:32];
    cmd.ramp_rate  = in_tdata[73:52];
    cmd.goal_steps = turns[srpc_pkg::TURNS_W-1] ? (srpc_pkg::POS_W'(0) - goal_mag) : goal_mag;
  end

endmodule
`default_nettype wire

// ===== rtl/srpc_queue.sv =====
// Short request queue between the front end and the execution back end.
`default_nettype none
`include "stepper_ramp_and_position_control_assert.svh"
module srpc_queue #(
  parameter int DEPTH = srpc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire srpc_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop,
  output srpc_pkg::cmd_t      pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  srpc_pkg::cmd_t   entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pull;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pull       = pop && pop_valid;
  assign pop_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pull) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pull})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `SRPC_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `SRPC_ASSERT_NXT(a_push_grows, clk, rst_n, push && !pull, count_r == $past(count_r) + CNT_W'(1))

endmodule
`default_nettype wire

// ===== rtl/srpc_back.sv =====
// Back end: executes queued requests against the motion state, drives the result register.
`default_nettype none
`include "stepper_ramp_and_position_control_assert.svh"
module srpc_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire srpc_pkg::cfg_t                  cfg,
  input  wire logic                            q_valid,
  input  wire srpc_pkg::cmd_t                  q_cmd,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [srpc_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int RW  = srpc_pkg::RPM_W;
  localparam int DW  = srpc_pkg::RPM_W + 3;
  localparam int MW  = srpc_pkg::TIME_W + srpc_pkg::SLOPE_W;
  localparam int QW  = srpc_pkg::PROD_W + 32;
  localparam int TW  = srpc_pkg::RPM_W + srpc_pkg::SPR_W;

  srpc_pkg::bk_state_t state_r, state_nxt;
  srpc_pkg::mode_t     mode_r, mode_nxt;
  logic signed [RW-1:0] speed_now_r, speed_now_nxt;
  logic signed [RW-1:0] speed_goal_r, speed_goal_nxt;
  logic [srpc_pkg::SLOPE_W-1:0] slope_r, slope_nxt;
  logic                 ramp_active_r, ramp_active_nxt;
  logic                 move_active_r, move_active_nxt;
  logic [srpc_pkg::TIME_W-1:0] ramp_last_r, ramp_last_nxt;
  logic [srpc_pkg::TIME_W-1:0] step_last_r, step_last_nxt;
  logic [srpc_pkg::POS_W-1:0]  goal_r, goal_nxt;
  logic [srpc_pkg::POS_W-1:0]  steps_r, steps_nxt;
  logic                 dir_r, dir_nxt;
  logic [srpc_pkg::TONE_W-1:0] tone_r, tone_nxt;
  logic [srpc_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [srpc_pkg::TIME_W-1:0] dt_r, dt_nxt;
  logic [srpc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [srpc_pkg::DELTA_W-1:0] d_r, d_nxt;
  logic                 out_valid_r;
  srpc_pkg::status_t    out_r;
  srpc_pkg::status_t    status;
  logic                 emit;
  logic                 pulse;

  logic                 out_free;
  logic                 exec_go;
  logic [srpc_pkg::TIME_W-1:0] ramp_dt, step_dt;
  logic                 ramp_due, step_due, tick_ramp;
  logic [MW-1:0]        mul_full;
  logic [srpc_pkg::PROD_W-1:0] prod_sat;
  logic [QW-1:0]        div_full;
  logic signed [DW-1:0] now_ext, goal_ext, d_ext, diff, rpm_wide;
  logic signed [RW-1:0] rpm_new;
  logic [RW-1:0]        spd_mag;
  logic [TW-1:0]        tone_full;
  logic [srpc_pkg::TONE_W-1:0] tone_sat;

  assign out_free  = !out_valid_r || out_tready;
  assign exec_go   = (state_r == srpc_pkg::BK_EXEC) && q_valid && out_free;
  assign q_pop     = exec_go;
  assign ramp_dt   = q_cmd.time_ms - ramp_last_r;
  assign step_dt   = q_cmd.time_ms - step_last_r;
  assign ramp_due  = ramp_active_r && (ramp_dt >= srpc_pkg::TIME_W'(cfg.ramp_period_ms));
  assign step_due  = move_active_r && (step_dt >= srpc_pkg::TIME_W'(cfg.step_period_ms));
  assign tick_ramp = exec_go && (q_cmd.kind == srpc_pkg::CMD_TICK) && ramp_due;

  assign mul_full  = MW'(dt_r) * MW'(slope_r);
  assign prod_sat  = (mul_full > MW'(srpc_pkg::PROD_MAX)) ? srpc_pkg::PROD_MAX
                                                          : mul_full[srpc_pkg::PROD_W-1:0];
  // exact floor(prod / 1000) for prod below 2^31
  assign div_full  = QW'(prod_r) * QW'(srpc_pkg::DIV1000_MAGIC);

  assign now_ext   = DW'(speed_now_r);
  assign goal_ext  = DW'(speed_goal_r);
  assign d_ext     = $signed({1'b0, d_r});
  assign diff      = goal_ext - now_ext;
  assign rpm_wide  = (diff > d_ext)  ? (now_ext + d_ext) :
                     (diff < -d_ext) ? (now_ext - d_ext) : goal_ext;
  assign rpm_new   = rpm_wide[RW-1:0];

  assign spd_mag   = speed_now_r[RW-1] ? (RW'(0) - speed_now_r) : speed_now_r;
  assign tone_full = TW'(spd_mag) * TW'(cfg.steps_per_sec_per_rpm);
  assign tone_sat  = (tone_full > TW'(srpc_pkg::TONE_MAX)) ? srpc_pkg::TONE_MAX
                                                           : tone_full[srpc_pkg::TONE_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srpc_pkg::BK_EXEC: if (tick_ramp) state_nxt = srpc_pkg::BK_MUL;
      srpc_pkg::BK_MUL:  state_nxt = srpc_pkg::BK_DIV;
      srpc_pkg::BK_DIV:  state_nxt = srpc_pkg::BK_UPD;
      srpc_pkg::BK_UPD:  state_nxt = srpc_pkg::BK_TONE;
      srpc_pkg::BK_TONE: if (out_free) state_nxt = srpc_pkg::BK_EXEC;
      default:           state_nxt = srpc_pkg::BK_EXEC;
    endcase
  end

  always_comb begin
    mode_nxt        = mode_r;
    speed_now_nxt   = speed_now_r;
    speed_goal_nxt  = speed_goal_r;
    slope_nxt       = slope_r;
    ramp_active_nxt = ramp_active_r;
    move_active_nxt = move_active_r;
    ramp_last_nxt   = ramp_last_r;
    step_last_nxt   = step_last_r;
    goal_nxt        = goal_r;
    steps_nxt       = steps_r;
    dir_nxt         = dir_r;
    tone_nxt        = tone_r;
    now_nxt         = now_r;
    dt_nxt          = dt_r;
    prod_nxt        = prod_r;
    d_nxt           = d_r;
    emit            = 1'b0;
    pulse           = 1'b0;
    case (state_r)
      srpc_pkg::BK_EXEC: begin
        if (exec_go) begin
          emit = !tick_ramp;
          case (q_cmd.kind)
            srpc_pkg::CMD_TICK: begin
              if (ramp_active_r) begin
                if (ramp_due) begin
                  now_nxt = q_cmd.time_ms;
                  dt_nxt  = ramp_dt;
                end
              end else if (step_due) begin
                if ($signed(goal_r) > $signed(steps_r)) begin
                  if (mode_r == srpc_pkg::MODE_IMPULSE) begin
                    dir_nxt = 1'b1;
                    pulse   = 1'b1;
                  end
                  steps_nxt = steps_r + srpc_pkg::POS_W'(1);
                end else if ($signed(goal_r) < $signed(steps_r)) begin
                  if (mode_r == srpc_pkg::MODE_IMPULSE) begin
                    dir_nxt = 1'b0;
                    pulse   = 1'b1;
                  end
                  steps_nxt = steps_r - srpc_pkg::POS_W'(1);
                end else begin
                  move_active_nxt = 1'b0;
                end
                step_last_nxt = q_cmd.time_ms;
              end
            end
            srpc_pkg::CMD_START: begin
              speed_goal_nxt  = q_cmd.target_rpm;
              slope_nxt       = q_cmd.ramp_rate;
              ramp_active_nxt = 1'b1;
            end
            srpc_pkg::CMD_ROTATE: begin
              goal_nxt        = q_cmd.goal_steps;
              move_active_nxt = 1'b1;
              mode_nxt        = srpc_pkg::MODE_IMPULSE;
            end
            srpc_pkg::CMD_RESREF: begin
              steps_nxt = '0;
            end
            srpc_pkg::CMD_STOP: begin
              move_active_nxt = 1'b0;
              ramp_active_nxt = 1'b0;
              speed_now_nxt   = '0;
              tone_nxt        = '0;
              dir_nxt         = 1'b1;
              mode_nxt        = srpc_pkg::MODE_OFF;
            end
            default: begin
            end
          endcase
        end
      end
      srpc_pkg::BK_MUL: begin
        prod_nxt = prod_sat;
      end
      srpc_pkg::BK_DIV: begin
        d_nxt = div_full[srpc_pkg::DIV_SHIFT +: srpc_pkg::DELTA_W];
      end
      srpc_pkg::BK_UPD: begin
        speed_now_nxt = rpm_new;
        mode_nxt      = (rpm_new != '0) ? srpc_pkg::MODE_RATE : srpc_pkg::MODE_OFF;
        dir_nxt       = !rpm_new[RW-1];
        if (rpm_new == speed_goal_r) begin
          ramp_active_nxt = 1'b0;
        end
        ramp_last_nxt = now_r;
      end
      srpc_pkg::BK_TONE: begin
        tone_nxt = tone_sat;
        emit     = out_free;
      end
      default: begin
      end
    endcase

    status.step_pulse     = pulse;
    status.step_dir       = dir_nxt;
    status.driver_enable  = (mode_nxt != srpc_pkg::MODE_OFF);
    status.drive_mode     = mode_nxt;
    status.step_rate      = (mode_nxt == srpc_pkg::MODE_RATE) ? tone_nxt : '0;
    status.speed_rpm      = speed_now_nxt;
    status.position_steps = steps_nxt;
    status.rotating       = move_active_nxt;
    status.ramping        = ramp_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= srpc_pkg::BK_EXEC;
      mode_r        <= srpc_pkg::MODE_OFF;
      speed_now_r   <= '0;
      speed_goal_r  <= '0;
      slope_r       <= srpc_pkg::SLOPE_RST;
      ramp_active_r <= 1'b0;
      move_active_r <= 1'b0;
      ramp_last_r   <= '0;
      step_last_r   <= '0;
      goal_r        <= '0;
      steps_r       <= '0;
      dir_r         <= 1'b0;
      tone_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      speed_now_r   <= speed_now_nxt;
      speed_goal_r  <= speed_goal_nxt;
      slope_r       <= slope_nxt;
      ramp_active_r <= ramp_active_nxt;
      move_active_r <= move_active_nxt;
      ramp_last_r   <= ramp_last_nxt;
      step_last_r   <= step_last_nxt;
      goal_r        <= goal_nxt;
      steps_r       <= steps_nxt;
      dir_r         <= dir_nxt;
      tone_r        <= tone_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    dt_r   <= dt_nxt;
    prod_r <= prod_nxt;
    d_r    <= d_nxt;
    if (emit) begin
      out_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = srpc_pkg::OUT_DATA_W'(out_r);

  `SRPC_ASSERT_IMP(a_pulse_impulse, clk, rst_n, out_valid_r && out_r.step_pulse,
                   out_r.drive_mode == srpc_pkg::MODE_IMPULSE)
  `SRPC_ASSERT_IMP(a_rate_only_rate, clk, rst_n, out_valid_r && (out_r.drive_mode != srpc_pkg::MODE_RATE),
                   out_r.step_rate == '0)
  `SRPC_ASSERT_IMP(a_mul_ramping, clk, rst_n, state_r == srpc_pkg::BK_MUL, ramp_active_r)

endmodule
`default_nettype wire

// ===== rtl/stepper_ramp_and_position_control.sv =====
// Stepper ramp and position controller: each request yields one registered result.
// Throughput one request per cycle while the result side accepts; a ramp tick that is due holds the back end
// in turn through slope multiply, reciprocal divide by 1000, speed update and step-rate multiply.
// The request queue lets the front keep accepting, until it is full, while the back end or result side stalls.
// rst_n is synchronous, active low: queue empties, motion state and registers take defaults.
`default_nettype none
module stepper_ramp_and_position_control #(
  parameter int QUEUE_DEPTH = srpc_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // opcode
  input  wire logic [srpc_pkg::IN_USER_W-1:0]   in_tuser,
  // time_ms, ramp_target_rpm, ramp_rate, target_turns
  input  wire logic [srpc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // step_pulse, step_dir, driver_enable, drive_mode, step_rate, speed_rpm,
  // position_steps, rotating, ramping, zero pad
  output logic [srpc_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [srpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  srpc_pkg::cfg_t cfg_r;
  srpc_pkg::cmd_t front_cmd;
  srpc_pkg::cmd_t head_cmd;
  logic           head_valid;
  logic           head_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_period_ms        <= srpc_pkg::RAMP_PERIOD_RST;
      cfg_r.step_period_ms        <= srpc_pkg::STEP_PERIOD_RST;
      cfg_r.steps_per_turn        <= srpc_pkg::STEPS_TURN_RST;
      cfg_r.steps_per_sec_per_rpm <= srpc_pkg::STEPS_RPM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        srpc_pkg::REG_RAMP_PERIOD: cfg_r.ramp_period_ms <= cfg_data;
        srpc_pkg::REG_STEP_PERIOD: cfg_r.step_period_ms <= cfg_data;
        srpc_pkg::REG_STEPS_TURN:  cfg_r.steps_per_turn <= cfg_data;
        srpc_pkg::REG_STEPS_RPM:
          cfg_r.steps_per_sec_per_rpm <= cfg_data[srpc_pkg::SPR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srpc_front u_front (
    .in_tuser       (in_tuser),
    .in_tdata       (in_tdata),
    .steps_per_turn (cfg_r.steps_per_turn),
    .cmd            (front_cmd)
  );

  srpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_cmd   (front_cmd),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_cmd    (head_cmd)
  );

  srpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (head_valid),
    .q_cmd      (head_cmd),
    .q_pop      (head_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the stepper ramp and position controller: predictor, scoreboard, random requests.
module tb;
  import srpc_pkg::*;

  localparam logic [IN_USER_W-1:0] OP_MAX_CODE = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int END_WAIT    = 12;
  localparam int TIME_LIMIT  = 2000000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state and register copy
  mode_t cur_mode;
  longint rpm_now, rpm_goal;
  longint unsigned ramp_slope, pulse_rate;
  bit ramp_on, move_on, dir_pin;
  logic [TIME_W-1:0] ramp_stamp, step_stamp;
  logic [POS_W-1:0] goal_pos, pos_now;
  logic [PERIOD_W-1:0] ramp_gap_ms, step_gap_ms;
  logic [SPT_W-1:0] turn_steps;
  logic [SPR_W-1:0] rate_per_rpm;

  status_t expected_status[$];
  logic [TIME_W-1:0] clock_ms = '0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  bit sink_hold = 1'b0;
  int fault_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int settings_used = 0;

  stepper_ramp_and_position_control dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic reset_model();
    ramp_gap_ms = RAMP_PERIOD_RST;
    step_gap_ms = STEP_PERIOD_RST;
    turn_steps = STEPS_TURN_RST;
    rate_per_rpm = STEPS_RPM_RST;
    cur_mode = MODE_OFF;
    rpm_now = 0;
    rpm_goal = 0;
    ramp_slope = SLOPE_RST;
    ramp_on = 1'b0;
    move_on = 1'b0;
    ramp_stamp = '0;
    step_stamp = '0;
    goal_pos = '0;
    pos_now = '0;
    dir_pin = 1'b0;
    pulse_rate = 0;
  endtask

  task automatic apply_speed(input longint rpm);
    longint unsigned mag, f;
    mag = (rpm < 0) ? -rpm : rpm;
    f = mag * rate_per_rpm;
    cur_mode = (rpm != 0) ? MODE_RATE : MODE_OFF;
    pulse_rate = (f > TONE_MAX) ? TONE_MAX : f;
    dir_pin = (rpm >= 0);
    rpm_now = rpm;
  endtask

  task automatic predict_status(input logic [IN_USER_W-1:0] op, input logic [TIME_W-1:0] ms,
                                input logic [RPM_W-1:0] rpm_in, input logic [SLOPE_W-1:0] rate_in,
                                input logic [TURNS_W-1:0] turns_in, output status_t st);
    logic [TIME_W-1:0] dt;
    logic signed [RPM_W-1:0] rpm_s;
    logic signed [TURNS_W-1:0] turns_s;
    longint d, diff, rpm, tl;
    longint unsigned mag, r;
    int gs, sn;
    bit pulse;
    pulse = 1'b0;
    case (op)
      OP_TICK: begin
        if (ramp_on) begin
          dt = ms - ramp_stamp;
          if (dt >= ramp_gap_ms) begin
            d = longint'((64'(dt) * ramp_slope) / 64'd1000);
            diff = rpm_goal - rpm_now;
            if (diff > d) rpm = rpm_now + d;
            else if (diff < -d) rpm = rpm_now - d;
            else rpm = rpm_goal;
            apply_speed(rpm);
            if (rpm == rpm_goal) ramp_on = 1'b0;
            ramp_stamp = ms;
          end
        end else if (move_on) begin
          dt = ms - step_stamp;
          if (dt >= step_gap_ms) begin
            gs = goal_pos;
            sn = pos_now;
            diff = longint'(gs) - longint'(sn);
            if (diff > 0) begin
              if (cur_mode == MODE_IMPULSE) begin
                dir_pin = 1'b1;
                pulse = 1'b1;
              end
              pos_now = pos_now + 1;
            end else if (diff < 0) begin
              if (cur_mode == MODE_IMPULSE) begin
                dir_pin = 1'b0;
                pulse = 1'b1;
              end
              pos_now = pos_now - 1;
            end else begin
              move_on = 1'b0;
            end
            step_stamp = ms;
          end
        end
      end
      OP_START: begin
        rpm_s = rpm_in;
        rpm_goal = rpm_s;
        ramp_slope = rate_in;
        ramp_on = 1'b1;
      end
      OP_ROTATE: begin
        turns_s = turns_in;
        tl = turns_s;
        mag = (tl < 0) ? -tl : tl;
        mag = mag * turn_steps;
        r = (mag + (64'd1 << (TURN_FRAC - 1))) >> TURN_FRAC;
        goal_pos = (tl < 0) ? 32'd0 - r[31:0] : r[31:0];
        move_on = 1'b1;
        cur_mode = MODE_IMPULSE;
      end
      OP_RESREF: pos_now = '0;
      OP_STOP: begin
        move_on = 1'b0;
        ramp_on = 1'b0;
        apply_speed(0);
        cur_mode = MODE_OFF;
      end
      default: ;
    endcase
    st.step_pulse = pulse;
    st.step_dir = dir_pin;
    st.driver_enable = (cur_mode != MODE_OFF);
    st.drive_mode = cur_mode;
    st.step_rate = (cur_mode == MODE_RATE) ? pulse_rate[TONE_W-1:0] : '0;
    st.speed_rpm = rpm_now[RPM_W-1:0];
    st.position_steps = pos_now;
    st.rotating = move_on;
    st.ramping = ramp_on;
  endtask

  task automatic send_cmd(input logic [IN_USER_W-1:0] op, input logic [TIME_W-1:0] ms,
                          input logic [RPM_W-1:0] rpm, input logic [SLOPE_W-1:0] rate,
                          input logic [TURNS_W-1:0] turns);
    status_t want;
    if (src_gaps && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {turns, rate, rpm, ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_status(op, ms, rpm, rate, turns, want);
    expected_status.push_back(want);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RAMP_PERIOD: ramp_gap_ms = val;
      REG_STEP_PERIOD: step_gap_ms = val;
      REG_STEPS_TURN:  turn_steps = val;
      REG_STEPS_RPM:   rate_per_rpm = val[SPR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] ramp_ms, input logic [CFG_DATA_W-1:0] step_ms,
                            input logic [CFG_DATA_W-1:0] spt, input logic [CFG_DATA_W-1:0] spr);
    wait_drained();
    write_reg(REG_RAMP_PERIOD, ramp_ms);
    write_reg(REG_STEP_PERIOD, step_ms);
    write_reg(REG_STEPS_TURN, spt);
    write_reg(REG_STEPS_RPM, spr);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [RPM_W-1:0] rand_rpm();
    case ($urandom_range(7))
      0: return RPM_W'($urandom);
      1: return 20'h80000;
      2: return 20'h7FFFF;
      3: return '0;
      default: return RPM_W'($urandom_range(0, 51200) - 25600);
    endcase
  endfunction

  function automatic logic [SLOPE_W-1:0] rand_rate();
    if ($urandom_range(9) == 0) return '0;
    return 22'($urandom) >> $urandom_range(0, 21);
  endfunction

  // mostly goals a dozen steps or so away, so moves finish
  function automatic logic [TURNS_W-1:0] rand_turns();
    int lim;
    if ($urandom_range(7) == 0) return TURNS_W'($urandom);
    lim = (turn_steps == 0) ? 4096 : (12 * 65536) / turn_steps + 1;
    return TURNS_W'($urandom_range(0, 2 * lim) - lim);
  endfunction

  task automatic send_tick();
    int span;
    span = 2 * (ramp_on ? ramp_gap_ms : step_gap_ms) + 2;
    case ($urandom_range(19))
      0: clock_ms = $urandom;
      1: clock_ms = clock_ms - $urandom_range(1, 100);
      2: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
      3: ;
      default: clock_ms = clock_ms + $urandom_range(0, span);
    endcase
    send_cmd(OP_TICK, clock_ms, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
  endtask

  task automatic run_mix(input int count, input int start_pct, input int rotate_pct);
    int done, pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < start_pct) begin
        send_cmd(OP_START, $urandom, rand_rpm(), rand_rate(), TURNS_W'($urandom));
      end else if (pick < start_pct + rotate_pct) begin
        send_cmd(OP_ROTATE, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), rand_turns());
      end else if (pick < start_pct + rotate_pct + 3) begin
        send_cmd(OP_RESREF, $urandom, RPM_W'($urandom), SLOPE_W'($urandom),
                 TURNS_W'($urandom));
      end else if (pick < start_pct + rotate_pct + 6) begin
        send_cmd(OP_STOP, $urandom, RPM_W'($urandom), SLOPE_W'($urandom),
                 TURNS_W'($urandom));
      end else if (pick < start_pct + rotate_pct + 8) begin
        send_cmd(3'($urandom_range(OP_STOP + 1, OP_MAX_CODE)), $urandom, RPM_W'($urandom),
                 SLOPE_W'($urandom), TURNS_W'($urandom));
        continue;
      end else begin
        send_tick();
      end
      done++;
    end
  endtask

  task automatic hold_sink(input int cycles);
    sink_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    sink_hold = 1'b0;
  endtask

  task automatic test_directed();
    logic [IN_USER_W-1:0] op;
    send_cmd(OP_TICK, 32'd0, '0, '0, '0);
    op = OP_STOP;
    repeat (OP_MAX_CODE - OP_STOP) begin
      op++;
      send_cmd(op, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    end
    send_cmd(OP_ROTATE, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), 30'h1FFF_FFFF);
    send_cmd(OP_TICK, 32'd2, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_TICK, 32'd3, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_ROTATE, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), 30'h2000_0000);
    send_cmd(OP_TICK, 32'd5, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_RESREF, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    // half-step goals round away from zero
    send_cmd(OP_ROTATE, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), 30'd512);
    send_cmd(OP_TICK, 32'd7, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_ROTATE, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), 30'h3FFF_FE00);
    send_cmd(OP_TICK, 32'd9, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_ROTATE, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), '0);
    send_cmd(OP_TICK, 32'd11, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    // ramp over a running move
    send_cmd(OP_ROTATE, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), 30'd512);
    send_cmd(OP_START, $urandom, 20'h7FFFF, 22'h3FFFFF, TURNS_W'($urandom));
    send_cmd(OP_TICK, 32'd100, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_TICK, 32'd150, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_START, $urandom, 20'h80000, 22'h3FFFFF, TURNS_W'($urandom));
    send_cmd(OP_TICK, 32'd450, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    // ramp to zero, then the move steps with the driver off
    send_cmd(OP_START, $urandom, '0, 22'h3FFFFF, TURNS_W'($urandom));
    send_cmd(OP_TICK, 32'd1000, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_TICK, 32'd1002, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_STOP, $urandom, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    send_cmd(OP_TICK, 32'd1010, RPM_W'($urandom), SLOPE_W'($urandom), TURNS_W'($urandom));
    clock_ms = 32'd1010;
  endtask

  task automatic test_speed_ramp();
    run_mix(250, 12, 3);
  endtask

  task automatic test_positioning();
    run_mix(250, 2, 12);
  endtask

  task automatic test_backpressure();
    fork
      hold_sink(HOLD_CYCLES);
    join_none
    run_mix(60, 5, 8);
    wait_drained();
  endtask

  task automatic test_streaming();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    run_mix(200, 5, 8);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_config_sweep();
    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    run_mix(160, 6, 8);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_mix(160, 6, 8);
    set_config(16'd1, 16'd1, 16'd1, 16'd1);
    run_mix(160, 6, 8);
    set_config(16'($urandom_range(2, 200)), 16'($urandom_range(2, 20)), 16'($urandom),
               16'($urandom));
    run_mix(160, 6, 8);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (fault_count < 10)
        $display("mismatch on %s in result %0d: expected %0h, got %0h", name, results_seen, want,
                 got);
      fault_count++;
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] word);
    status_t got, want;
    got = word[$bits(status_t)-1:0];
    results_seen++;
    if (expected_status.size() == 0) begin
      if (fault_count < 10) $display("result %0d arrived with no request outstanding", results_seen);
      fault_count++;
    end else begin
      want = expected_status.pop_front();
      check_field("step_pulse", want.step_pulse, got.step_pulse);
      check_field("step_dir", want.step_dir, got.step_dir);
      check_field("driver_enable", want.driver_enable, got.driver_enable);
      check_field("drive_mode", want.drive_mode, got.drive_mode);
      check_field("step_rate", want.step_rate, got.step_rate);
      check_field("speed_rpm", want.speed_rpm, got.speed_rpm);
      check_field("position_steps", want.position_steps, got.position_steps);
      check_field("rotating", want.rotating, got.rotating);
      check_field("ramping", want.ramping, got.ramping);
      check_field("pad", '0, word[OUT_DATA_W-1:$bits(status_t)]);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
    if (sink_hold) out_tready <= 1'b0;
    else if (sink_gaps && $urandom_range(99) < 10) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  initial begin
    int guard;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_speed_ramp();
    test_positioning();
    test_backpressure();
    test_streaming();
    test_config_sweep();
    in_tvalid <= 1'b0;
    guard = 0;
    while (expected_status.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (END_WAIT) @(posedge clk);
    if (expected_status.size() != 0) begin
      $display("%0d expected results never arrived", expected_status.size());
      fault_count += expected_status.size();
    end
    $display("covered %0d requests (all commands, unknown codes, time wrap) and %0d results",
             requests_sent, results_seen);
    $display("over %0d register settings, a %0d-cycle result stall and a gap-free stretch",
             settings_used + 1, HOLD_CYCLES);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
